FILE: rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg
// shared constants, controller states and command/status bundles for the
// palindrome minimum-cut block
// ----------------------------------------------------------------------------
package pmc_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int CUT_W       = 6;
    localparam int CUT_MAX     = 63;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic item_full;
        logic scan_end;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/palindrome_min_cut_top.sv
// ----------------------------------------------------------------------------
// palindrome_min_cut_top
// minimum palindrome partition cuts of a streamed string, one result beat
// per symbol beat
//
//   channel  handshake            payload
//   in       in_valid / in_stall  symbol[7:0], last
//   out      out_valid/ out_stall min_cuts[5:0], last_res, overflow
//
// a symbol at string position p passes an accept, p+1 scan steps over the
// stored symbols (one store read per step), one drain and one commit
// a symbol beyond MAX_LEN skips the scan and drain and is not stored
// reset clears control state only; no clearing pass is needed
// out_stall holds the result register and blocks the commit of the next beat
// ----------------------------------------------------------------------------
module palindrome_min_cut_top #(
    parameter int MAX_LEN = pmc_pkg::MAX_LEN_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [pmc_pkg::SYM_W-1:0] symbol,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [pmc_pkg::CUT_W-1:0] min_cuts,
    output logic                      last_res,
    output logic                      overflow
);

    pmc_pkg::cmd_t    cmd;
    pmc_pkg::status_t status;

    pmc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pmc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol    (symbol),
        .last      (last),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .min_cuts  (min_cuts),
        .last_res  (last_res),
        .overflow  (overflow)
    );

endmodule

FILE: rtl/pmc_ctrl.sv
// ----------------------------------------------------------------------------
// pmc_ctrl
// sequencer: accepts a beat, steps the scan over stored symbols (skipped for
// a beat beyond MAX_LEN), then commits the result into the output register
// ----------------------------------------------------------------------------
module pmc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pmc_pkg::status_t status,
    output pmc_pkg::cmd_t    cmd
);

    pmc_pkg::state_t state_reg;
    pmc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.item_full ? pmc_pkg::ST_DONE : pmc_pkg::ST_SCAN;
                end
            end
            pmc_pkg::ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = pmc_pkg::ST_DRAIN;
                end
            end
            pmc_pkg::ST_DRAIN:
            begin
                state_next = pmc_pkg::ST_DONE;
            end
            pmc_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = pmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            pmc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            pmc_pkg::ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            pmc_pkg::ST_DRAIN:
            begin
                cmd.issue = 1'b0;
            end
            pmc_pkg::ST_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/pmc_datapath.sv
// ----------------------------------------------------------------------------
// pmc_datapath
// symbol, palindrome-row and prefix-cut stores, scan counter, compare and
// minimum stage, position tracking and the output register
// ----------------------------------------------------------------------------
module pmc_datapath #(
    parameter int MAX_LEN = pmc_pkg::MAX_LEN_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pmc_pkg::SYM_W-1:0] symbol,
    input  logic                      last,
    input  logic                      out_stall,
    input  pmc_pkg::cmd_t             cmd,
    output pmc_pkg::status_t          status,
    output logic                      out_valid,
    output logic [pmc_pkg::CUT_W-1:0] min_cuts,
    output logic                      last_res,
    output logic                      overflow
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int POS_W = $clog2(MAX_LEN + 1);

    logic [pmc_pkg::SYM_W-1:0] sym_mem [MAX_LEN];
    logic                      row_mem [MAX_LEN];
    logic [IDX_W-1:0]          cut_mem [MAX_LEN];

    logic [POS_W-1:0]          pos_reg;
    logic                      ovf_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      rd_valid_reg;

    logic [pmc_pkg::SYM_W-1:0] sym_reg;
    logic                      last_reg;
    logic [IDX_W-1:0]          j_reg;
    logic [IDX_W-1:0]          rd_j_reg;
    logic [IDX_W-1:0]          best_reg;
    logic [IDX_W-1:0]          best_next;
    logic [IDX_W-1:0]          last_cuts_reg;
    logic [pmc_pkg::SYM_W-1:0] sym_rd_reg;
    logic                      row_rd_reg;
    logic [IDX_W-1:0]          cut_rd_reg;
    logic [pmc_pkg::CUT_W-1:0] min_cuts_reg;
    logic                      last_res_reg;
    logic                      overflow_reg;

    logic [IDX_W-1:0]          p_idx;
    logic                      full;
    logic                      inner;
    logic                      pal;
    logic [IDX_W-1:0]          cand;
    logic [IDX_W-1:0]          res_cuts;
    logic [pmc_pkg::CUT_W-1:0] res_sat;

    assign p_idx = pos_reg[IDX_W-1:0];
    assign full  = (pos_reg == POS_W'(MAX_LEN));
    assign inner = ({1'b0, pos_reg} <= ((POS_W + 1)'(rd_j_reg) + (POS_W + 1)'(1)));
    assign pal   = (sym_rd_reg == sym_reg) && (inner || row_rd_reg);
    assign cand  = (rd_j_reg == '0) ? '0 : (cut_rd_reg + IDX_W'(1));

    assign res_cuts = full ? last_cuts_reg : best_reg;
    assign res_sat  = (32'(res_cuts) > 32'(pmc_pkg::CUT_MAX)) ?
                      pmc_pkg::CUT_W'(pmc_pkg::CUT_MAX) : pmc_pkg::CUT_W'(res_cuts);

    always_comb
    begin
        best_next = best_reg;
        if (cmd.load)
        begin
            best_next = p_idx;
        end
        else if (rd_valid_reg && pal && (cand < best_reg))
        begin
            best_next = cand;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= cmd.issue;
            if (cmd.load && full)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                if (last_reg)
                begin
                    pos_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else if (!full)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    // scan datapath and stores
    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (cmd.load)
        begin
            sym_reg  <= symbol;
            last_reg <= last;
            j_reg    <= '0;
            if (!full)
            begin
                sym_mem[p_idx] <= symbol;
            end
        end
        if (cmd.issue)
        begin
            sym_rd_reg <= sym_mem[j_reg];
            row_rd_reg <= row_mem[j_reg + IDX_W'(1)];
            cut_rd_reg <= cut_mem[j_reg - IDX_W'(1)];
            rd_j_reg   <= j_reg;
            j_reg      <= j_reg + IDX_W'(1);
        end
        if (rd_valid_reg)
        begin
            row_mem[rd_j_reg] <= pal;
        end
        if (cmd.finish)
        begin
            min_cuts_reg <= res_sat;
            last_res_reg <= last_reg;
            overflow_reg <= ovf_reg;
            if (!full)
            begin
                cut_mem[p_idx] <= best_reg;
                last_cuts_reg  <= best_reg;
            end
        end
    end

    assign status.item_full = full;
    assign status.scan_end  = (j_reg == p_idx);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign min_cuts  = min_cuts_reg;
    assign last_res  = last_res_reg;
    assign overflow  = overflow_reg;

endmodule
